/* rtl/core/crlu_pkg.sv */
// Shared types and constants for the chunk run-length unpacker.
// Used by crlu_engine and chunk_run_length_unpacker_core; no dependencies.
package crlu_pkg;

	localparam logic [7:0] MODE_LITERAL = 8'h00;
	localparam logic [7:0] MODE_REPEAT  = 8'h01;
	localparam logic [7:0] MODE_TWICE   = 8'h02;
	localparam logic [7:0] MODE_ZERO    = 8'h03;
	localparam logic [7:0] MODE_NOP     = 8'hFF;

	localparam int unsigned WORD_BYTES = 4;
	localparam int unsigned REM_W      = 11;

	typedef enum logic [2:0] {
		PH_MODE    = 3'd0,
		PH_COUNT   = 3'd1,
		PH_WORD    = 3'd2,
		PH_LITERAL = 3'd3,
		PH_LIT_OUT = 3'd4,
		PH_EMIT    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_MODE  = 2'd1,
		ERR_TRUNC = 2'd2,
		ERR_BUSY  = 2'd3
	} err_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] in_byte;
		logic       in_last;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       run_last;
		logic       need_input;
		logic [1:0] error_code;
		logic       done_res;
	} result_t;

endpackage

/* rtl/core/crlu_engine.sv */
// Decoder state and the single-pass update for one push or pull transaction.
// Depends on crlu_pkg.
module crlu_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  crlu_pkg::item_t  item,
	input  logic             reverse_word_bytes,
	output crlu_pkg::result_t result
);
	import crlu_pkg::*;

	phase_t           phase_q, phase_d;
	logic [1:0]       mode_q, mode_d;
	logic [7:0]       run_q, run_d;
	logic [31:0]      fill_q, fill_d;
	logic [1:0]       idx_q, idx_d;
	logic [REM_W-1:0] rem_q, rem_d;
	logic [7:0]       lit_q, lit_d;
	err_t             err_q, err_d;
	logic             ended_q, ended_d;

	logic [REM_W-1:0] emit_cnt;
	logic [1:0]       sel;
	logic             wants_more;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MODE;
			mode_q  <= 2'd0;
			run_q   <= 8'd0;
			fill_q  <= 32'd0;
			idx_q   <= 2'd0;
			rem_q   <= '0;
			lit_q   <= 8'd0;
			err_q   <= ERR_NONE;
			ended_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			mode_q  <= mode_d;
			run_q   <= run_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			rem_q   <= rem_d;
			lit_q   <= lit_d;
			err_q   <= err_d;
			ended_q <= ended_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		mode_d  = mode_q;
		run_d   = run_q;
		fill_d  = fill_q;
		idx_d   = idx_q;
		rem_d   = rem_q;
		lit_d   = lit_q;
		err_d   = err_q;
		ended_d = ended_q;
		emit_cnt = '0;
		sel = 2'd0;
		wants_more = 1'b0;
		result = '0;

		if (err_q == ERR_NONE) begin
			if (!item.opcode) begin
				if (!ended_q) begin
					unique case (phase_q)
						PH_MODE: begin
							if (item.in_byte == MODE_LITERAL || item.in_byte == MODE_REPEAT
									|| item.in_byte == MODE_ZERO) begin
								mode_d  = item.in_byte[1:0];
								phase_d = PH_COUNT;
							end else if (item.in_byte == MODE_TWICE) begin
								mode_d  = item.in_byte[1:0];
								idx_d   = 2'd0;
								fill_d  = 32'd0;
								phase_d = PH_WORD;
							end else if (item.in_byte != MODE_NOP) begin
								err_d = ERR_MODE;
							end
						end
						PH_COUNT: begin
							run_d = item.in_byte;
							if (mode_q == MODE_LITERAL[1:0]) begin
								phase_d = (item.in_byte != 8'd0) ? PH_LITERAL : PH_MODE;
							end else if (mode_q == MODE_ZERO[1:0]) begin
								rem_d   = {{(REM_W-8){1'b0}}, item.in_byte};
								idx_d   = 2'd0;
								phase_d = (item.in_byte != 8'd0) ? PH_EMIT : PH_MODE;
							end else begin
								idx_d   = 2'd0;
								fill_d  = 32'd0;
								phase_d = PH_WORD;
							end
						end
						PH_WORD: begin
							fill_d = {fill_q[23:0], item.in_byte};
							idx_d  = idx_q + 2'd1;
							if (idx_q == 2'd3) begin
								if (mode_q == MODE_TWICE[1:0]) begin
									emit_cnt = REM_W'(2 * WORD_BYTES);
								end else begin
									emit_cnt = {{(REM_W-10){1'b0}}, run_q, 2'b00};
								end
								rem_d   = emit_cnt;
								idx_d   = 2'd0;
								phase_d = (emit_cnt != '0) ? PH_EMIT : PH_MODE;
							end
						end
						PH_LITERAL: begin
							lit_d   = item.in_byte;
							run_d   = run_q - 8'd1;
							phase_d = PH_LIT_OUT;
						end
						default: begin
							err_d = ERR_BUSY;
						end
					endcase
					if (err_d == ERR_NONE && item.in_last) begin
						ended_d = 1'b1;
						wants_more = (phase_d == PH_COUNT) || (phase_d == PH_WORD)
							|| (phase_d == PH_LITERAL)
							|| (phase_d == PH_LIT_OUT && run_d != 8'd0);
						if (wants_more) begin
							err_d = ERR_TRUNC;
						end
					end
				end
			end else if (phase_q == PH_LIT_OUT) begin
				result.out_byte  = lit_q;
				result.out_valid = 1'b1;
				result.run_last  = (run_q == 8'd0);
				phase_d = (run_q != 8'd0) ? PH_LITERAL : PH_MODE;
			end else if (phase_q == PH_EMIT) begin
				if (mode_q != MODE_ZERO[1:0]) begin
					sel = reverse_word_bytes ? idx_q : ~idx_q;
					result.out_byte = fill_q[{sel, 3'b000} +: 8];
					idx_d = idx_q + 2'd1;
				end
				result.out_valid = 1'b1;
				rem_d = rem_q - REM_W'(1);
				result.run_last = (rem_d == '0);
				if (rem_d == '0) begin
					phase_d = PH_MODE;
				end
			end
		end

		result.need_input = (phase_d != PH_EMIT) && (phase_d != PH_LIT_OUT)
			&& (err_d == ERR_NONE) && !ended_d;
		result.error_code = err_d;
		result.done_res   = ended_d && (phase_d == PH_MODE) && (err_d == ERR_NONE);
	end

endmodule

/* rtl/core/chunk_run_length_unpacker_core.sv */
// Top level of the chunk run-length unpacker: input register, decoder engine,
// result register and the configuration register. Depends on crlu_pkg and crlu_engine.
//
// Usage: each slave transaction is one command to the decoder. s_tuser is the
// opcode: 0 pushes the packed byte in s_tdata, with s_tlast marking the final
// byte of the stream; 1 pulls one decoded byte. Every input transaction yields
// exactly one master transaction carrying the decoded byte, its flags and the
// decoder status after that step. m_tuser says whether a byte was delivered and
// m_tlast marks the last byte of a run.
// A transaction accepted at a clock edge sits in the input register, passes
// through the engine and is then registered in the result register, with
// m_tvalid high. Throughput is one transaction per cycle while the receiver
// does not stall; the engine state update is the only loop.
// When the receiver stalls, the result register holds and the input register
// fills; s_tready falls only when both are occupied and m_tready is low.
// Reset clears the decoder to wait for a mode byte, clears the error, the
// end-of-stream mark and the byte-order register, and empties both registers.
// cfg_we writes cfg_wdata to the byte-order register; write it only while idle.
module chunk_run_length_unpacker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] in_byte
	input  logic        s_tuser,  // [0] opcode
	input  logic        s_tlast,  // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] out_byte, [8] need_input, [10:9] error_code,
	                              // [11] done_res, [15:12] zero
	output logic        m_tuser,  // [0] out_valid
	output logic        m_tlast   // run_last
);
	import crlu_pkg::*;

	logic    reverse_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t res_q;
	result_t res_d;
	logic    out_free;
	logic    step;

	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			reverse_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= '{opcode: s_tuser, in_byte: s_tdata, in_last: s_tlast};
		end
	end

	crlu_engine u_engine (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (step),
		.item               (item_s1),
		.reverse_word_bytes (reverse_q),
		.result             (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q.done_res, res_q.error_code, res_q.need_input,
		res_q.out_byte};
	assign m_tuser  = res_q.out_valid;
	assign m_tlast  = res_q.run_last;

	a_no_byte_with_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[10:9] == ERR_NONE)
		else $error("decoded byte delivered while an error is held");

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> !m_tlast && m_tdata[7:0] == 8'd0)
		else $error("byte or run end flagged without a delivered byte");

	a_need_vs_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[8] && m_tdata[11]))
		else $error("need_input and done_res both set");

	a_error_blocks_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10:9] != ERR_NONE |-> !m_tdata[8] && !m_tdata[11])
		else $error("status flags set while an error is held");

endmodule
